/* rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Request and status codes and the control structs shared by the sorted key
// table cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

	// request kinds, carried on s_tuser
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// operation broadcast to every cell; only set for a committed change
	typedef struct packed {
		logic ins;
		logic del;
		logic clr;
	} cell_op_t;

	// per-cell compare results and occupancy
	typedef struct packed {
		logic occ;
		logic lt;
		logic eq;
	} cell_stat_t;

endpackage

`default_nettype wire

/* rtl/skt_cell.sv */
// ----------------------------------------------------------------------------
// skt_cell
// One table position: holds a key and an occupancy bit, compares its key
// against the request key and moves keys to or from its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
	parameter int KEY_WIDTH = 32
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire skt_pkg::cell_op_t   op,
	input  wire  [KEY_WIDTH-1:0]     req_key,
	// lower neighbour (position below); cell 0 sees a permanent "less than"
	input  wire                      prev_lt,
	input  wire                      prev_occ,
	input  wire  [KEY_WIDTH-1:0]     prev_key,
	// upper neighbour (position above); the top cell sees an empty one
	input  wire                      next_occ,
	input  wire  [KEY_WIDTH-1:0]     next_key,
	output skt_pkg::cell_stat_t      stat,
	output logic [KEY_WIDTH-1:0]     key
);

	logic                 occ_q;
	logic [KEY_WIDTH-1:0] key_q;

	// compare against the request key
	always_comb begin
		stat.occ = occ_q;
		stat.lt  = occ_q && (key_q < req_key);
		stat.eq  = occ_q && (key_q == req_key);
	end

	assign key = key_q;

	// occupancy is a prefix; it moves one place with each insert or delete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (op.clr) begin
			occ_q <= 1'b0;
		end else if (op.ins) begin
			occ_q <= prev_occ;
		end else if (op.del) begin
			occ_q <= next_occ;
		end
	end

	// keys at or above the insert/delete point move; smaller keys stay
	always_ff @(posedge clk) begin
		if (op.ins && !stat.lt) begin
			key_q <= prev_lt ? req_key : prev_key;
		end else if (op.del && !stat.lt) begin
			key_q <= next_key;
		end
	end

endmodule

`default_nettype wire

/* rtl/skt_onehot_enc.sv */
// ----------------------------------------------------------------------------
// skt_onehot_enc
// Turns a one-hot (or all-zero) position vector into a binary index.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_onehot_enc #(
	parameter int DEPTH = 16
) (
	input  wire  [DEPTH-1:0]         vec,
	output logic [$clog2(DEPTH)-1:0] idx
);

	localparam int IDX_W = $clog2(DEPTH);

	// each index bit is the OR of the positions that have that bit set
	always_comb begin
		idx = '0;
		for (int b = 0; b < IDX_W; b++) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (((i >> b) & 1) != 0) begin
					idx[b] = idx[b] | vec[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/sorted_key_table.sv */
// ----------------------------------------------------------------------------
// sorted_key_table
// Ascending table of unique unsigned keys held in a row of cells, with
// insert, delete and clear requests and one result per request.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                          | tuser
//  ----------+-----+--------------------------------+-------------------
//  s_ (req)  | in  | key                            | req_type
//  m_ (res)  | out | status, entry_total, slot      | -
//
//  Requests are resolved combinationally: all cells compare in parallel and
//  shift together at the accepting edge, one request per cycle while s_tready.
//  The result appears in the output register the cycle after acceptance.
//  A new request is taken whenever the output register is empty or being
//  drained, so a stalled result stops input only while it is held.
//  Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [((KEY_WIDTH+7)/8)*8-1:0]        s_tdata,  // key
	input  wire  [1:0]                            s_tuser,  // req_type
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// status, entry_total, slot (lowest bits first)
	output logic [((2+$clog2(DEPTH+1)+$clog2(DEPTH)+7)/8)*8-1:0] m_tdata
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int OUT_W  = 2 + CNT_W + SLOT_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	skt_pkg::cell_op_t   op;
	skt_pkg::cell_stat_t stat [DEPTH];
	logic [KEY_WIDTH-1:0] cell_key [DEPTH];
	logic [KEY_WIDTH-1:0] req_key;
	logic [1:0]           req_type;
	logic                 s_acc;

	logic [CNT_W-1:0]  count_q;
	logic [DEPTH-1:0]  eq_vec, bnd_vec, occ_vec, sel_vec;
	logic              any_eq, full;
	logic [SLOT_W-1:0] hit_idx;

	logic [1:0]        status_d;
	logic [CNT_W-1:0]  count_d;
	logic [SLOT_W-1:0] slot_d;

	logic [1:0]        status_q;
	logic [CNT_W-1:0]  total_q;
	logic [SLOT_W-1:0] slot_q;

	assign req_key  = s_tdata[KEY_WIDTH-1:0];
	assign req_type = s_tuser;
	assign s_tready = !m_tvalid || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 p_lt, p_occ, n_occ;
		logic [KEY_WIDTH-1:0] p_key, n_key;

		if (i == 0) begin : g_first
			assign p_lt  = 1'b1;
			assign p_occ = 1'b1;
			assign p_key = req_key;
		end else begin : g_mid
			assign p_lt  = stat[i-1].lt;
			assign p_occ = stat[i-1].occ;
			assign p_key = cell_key[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign n_occ = 1'b0;
			assign n_key = cell_key[i];
		end else begin : g_low
			assign n_occ = stat[i+1].occ;
			assign n_key = cell_key[i+1];
		end

		skt_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.req_key (req_key),
			.prev_lt (p_lt),
			.prev_occ(p_occ),
			.prev_key(p_key),
			.next_occ(n_occ),
			.next_key(n_key),
			.stat    (stat[i]),
			.key     (cell_key[i])
		);

		assign eq_vec[i]  = stat[i].eq;
		assign occ_vec[i] = stat[i].occ;
		// first position not below the key
		assign bnd_vec[i] = !stat[i].lt && p_lt;
	end

	assign any_eq = |eq_vec;
	assign full   = (count_q == CNT_W'(DEPTH));

	// insert slot comes from the boundary, delete slot from the match
	assign sel_vec = (req_type == skt_pkg::REQ_INSERT) ? bnd_vec : eq_vec;

	skt_onehot_enc #(
		.DEPTH(DEPTH)
	) u_enc (
		.vec(sel_vec),
		.idx(hit_idx)
	);

	// request decode and result
	always_comb begin
		op       = '0;
		status_d = skt_pkg::ST_OK;
		count_d  = count_q;
		slot_d   = '0;
		case (req_type)
			skt_pkg::REQ_INSERT: begin
				if (any_eq) begin
					status_d = skt_pkg::ST_DUP;
				end else if (full) begin
					status_d = skt_pkg::ST_FULL;
				end else begin
					op.ins  = s_acc;
					count_d = count_q + CNT_W'(1);
					slot_d  = hit_idx;
				end
			end
			skt_pkg::REQ_DELETE: begin
				if (any_eq) begin
					op.del  = s_acc;
					count_d = count_q - CNT_W'(1);
					slot_d  = hit_idx;
				end else begin
					status_d = skt_pkg::ST_MISSING;
				end
			end
			skt_pkg::REQ_CLEAR: begin
				op.clr  = s_acc;
				count_d = '0;
			end
			default: begin
				status_d = skt_pkg::ST_OK;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_acc) begin
			count_q <= count_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_acc) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			status_q <= status_d;
			total_q  <= count_d;
			slot_q   <= slot_d;
		end
	end

	assign m_tdata = OUT_TW'({slot_q, total_q, status_q});

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && req_type == skt_pkg::REQ_CLEAR) |=>
			(m_tvalid && total_q == '0 && count_q == '0))
		else $error("clear did not empty the table");

	for (genvar j = 0; j + 1 < DEPTH; j++) begin : g_chk_order
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(occ_vec[j+1] |-> (occ_vec[j] && cell_key[j] < cell_key[j+1])))
			else $error("table keys out of order");
	end

endmodule

`default_nettype wire

/* tb/tb_sorted_key_table.sv */
// ----------------------------------------------------------------------------
// tb_sorted_key_table
// Self-checking bench for the sorted key table. Requests are queued by an
// initial block: a directed opening that covers both key extremes, duplicates,
// misses, a full table and clears, then random streams in phases that are
// insert-heavy, balanced or delete-heavy, mostly over a small pool of keys. Each
// accepted request is run through a local copy of the table, and every result
// is checked field by field against the oldest prediction. Random stalls on
// both sides, with one stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_sorted_key_table;

	localparam int TB_DEPTH     = 16;
	localparam int RANDOM_REQS  = 1850;
	localparam int POOL_SIZE    = 20;
	localparam int IDLE_PCT     = 24;
	// request code left unused by the block; it must be ignored
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
	} table_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] entry_total;
		logic [3:0] slot;
	} table_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // key
	logic [1:0]  s_tuser;   // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // status, entry_total, slot (lowest bits first)

	table_req_t    pending_reqs[$];
	table_result_t expected_results[$];

	// local copy of the table
	logic [31:0] sorted_keys[TB_DEPTH];
	int          key_count;

	logic [31:0] key_pool[POOL_SIZE];
	int          reqs_taken;
	int          error_count;
	int          n_inserted, n_removed, n_dup, n_full, n_missing, n_clear, n_spare;

	sorted_key_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// no stalls on either side while this window of requests goes through
	function automatic bit full_rate();
		return reqs_taken >= 700 && reqs_taken < 950;
	endfunction

	// apply one request to the local table and return the result it gives
	function automatic table_result_t table_apply(input logic [1:0] kind,
			input logic [31:0] key);
		table_result_t res;
		int            pos;
		bit            hit;
		res.status = skt_pkg::ST_OK;
		res.slot   = '0;
		pos = 0;
		while (pos < key_count && sorted_keys[pos] < key)
			pos++;
		hit = pos < key_count && sorted_keys[pos] == key;
		case (kind)
			skt_pkg::REQ_INSERT: begin
				if (hit) begin
					res.status = skt_pkg::ST_DUP;
					n_dup++;
				end else if (key_count >= TB_DEPTH) begin
					res.status = skt_pkg::ST_FULL;
					n_full++;
				end else begin
					for (int i = key_count; i > pos; i--)
						sorted_keys[i] = sorted_keys[i-1];
					sorted_keys[pos] = key;
					key_count++;
					res.slot = pos[3:0];
					n_inserted++;
				end
			end
			skt_pkg::REQ_DELETE: begin
				if (hit) begin
					for (int i = pos; i + 1 < key_count; i++)
						sorted_keys[i] = sorted_keys[i+1];
					key_count--;
					res.slot = pos[3:0];
					n_removed++;
				end else begin
					res.status = skt_pkg::ST_MISSING;
					n_missing++;
				end
			end
			skt_pkg::REQ_CLEAR: begin
				key_count = 0;
				n_clear++;
			end
			default: n_spare++;
		endcase
		res.entry_total = key_count[4:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// request driver: predicts on acceptance, then presents the next request
	always @(posedge clk or negedge arst_n) begin
		table_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(table_apply(s_tuser, s_tdata));
				reqs_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 &&
						(full_rate() || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.key;
					s_tuser  <= nxt.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output back-pressure
	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, status", m_tdata[1:0], -1);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[1:0] !== want.status)
						report_mismatch("status", m_tdata[1:0], want.status);
					if (m_tdata[6:2] !== want.entry_total)
						report_mismatch("entry_total", m_tdata[6:2], want.entry_total);
					if (m_tdata[10:7] !== want.slot)
						report_mismatch("slot", m_tdata[10:7], want.slot);
				end
			end
			m_tready <= full_rate() || $urandom_range(99) >= IDLE_PCT;
		end
	end

	task automatic queue_req(input logic [1:0] kind, input logic [31:0] key);
		table_req_t r;
		r.kind = kind;
		r.key  = key;
		pending_reqs.push_back(r);
	endtask

	// stimulus and end of run
	initial begin
		int insert_pct;
		int pick;
		logic [1:0]  kind;
		logic [31:0] key;
		clk         = 1'b0;
		arst_n      = 1'b0;
		key_count   = 0;
		reqs_taken  = 0;
		error_count = 0;
		n_inserted = 0; n_removed = 0; n_dup = 0; n_full = 0;
		n_missing  = 0; n_clear   = 0; n_spare = 0;

		// directed: empty table, extremes, duplicate, misses, slot 0 and top
		queue_req(skt_pkg::REQ_DELETE, 32'd5);
		queue_req(skt_pkg::REQ_INSERT, 32'h0000_0000);
		queue_req(skt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
		queue_req(skt_pkg::REQ_INSERT, 32'h0000_0000);
		queue_req(skt_pkg::REQ_INSERT, 32'h8000_0000);
		queue_req(skt_pkg::REQ_DELETE, 32'h7FFF_FFFF);
		queue_req(skt_pkg::REQ_DELETE, 32'hFFFF_FFFF);
		queue_req(skt_pkg::REQ_DELETE, 32'h0000_0000);
		queue_req(skt_pkg::REQ_CLEAR,  32'hA5A5_5A5A);
		// fill in descending order so every insert lands in slot 0
		for (int i = 0; i < TB_DEPTH; i++)
			queue_req(skt_pkg::REQ_INSERT, 32'hF000_0001 - i * 32'h1000_0000);
		// full table: new key, duplicate (wins over full), spare code, clear
		queue_req(skt_pkg::REQ_INSERT, 32'h0800_0000);
		queue_req(skt_pkg::REQ_INSERT, 32'h7000_0001);
		queue_req(REQ_SPARE,  32'h1234_5678);
		queue_req(skt_pkg::REQ_CLEAR,  32'd0);

		// small pool of keys so that hits, duplicates and a full table are common
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		insert_pct = 50;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			// phases that grow, drain or churn the table
			if (n % 60 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 20;
				endcase
			end
			pick = $urandom_range(99);
			if (pick < 2)
				kind = REQ_SPARE;
			else if (pick < 5)
				kind = skt_pkg::REQ_CLEAR;
			else if ($urandom_range(99) < insert_pct)
				kind = skt_pkg::REQ_INSERT;
			else
				kind = skt_pkg::REQ_DELETE;
			if ($urandom_range(99) < 75)
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				key = $urandom;
			queue_req(kind, key);
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// run until every request is sent and every result is checked
		while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Requests: %0d; inserted %0d, removed %0d, clears %0d, spare code %0d",
			reqs_taken, n_inserted, n_removed, n_clear, n_spare);
		$display("Rejected: %0d duplicate, %0d on full table, %0d key not found",
			n_dup, n_full, n_missing);
		if (error_count == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/skt_onehot_enc.sv
rtl/sorted_key_table.sv
tb/tb_sorted_key_table.sv
